@@ rtl/three_axis_trimmed_mean_decimator_unit_macros.svh @@
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk; rst_n is active low.
`ifndef THREE_AXIS_TRIMMED_MEAN_DECIMATOR_UNIT_MACROS_SVH
`define THREE_AXIS_TRIMMED_MEAN_DECIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define TMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define TMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is applied.
`define TMD_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tmd_pkg.sv @@
`timescale 1ns / 1ps
package tmd_pkg;

  localparam int unsigned AXES        = 3;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned SUM_W       = 20;
  localparam int unsigned TRIM_W      = 21;
  localparam int unsigned MAG_W       = 19;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned QUO_W       = 17;
  localparam int unsigned RECIP_SH    = 24;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned SAMPLES_DEF = 10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [MAG_W-1:0]           mag_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  // Closing totals of one window, per axis
  typedef struct packed {
    sum_t    [AXES-1:0] sum;
    sample_t [AXES-1:0] lo;
    sample_t [AXES-1:0] hi;
  } win_t;

  // Trimmed total as sign and magnitude, per axis
  typedef struct packed {
    logic [AXES-1:0]    neg;
    mag_t [AXES-1:0]    mag;
  } trim_t;

endpackage

@@ rtl/tmd_accum.sv @@
`timescale 1ns / 1ps
module tmd_accum #(
  parameter int unsigned SAMPLES = tmd_pkg::SAMPLES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tmd_pkg::sample_t in_sample_x,
  input  tmd_pkg::sample_t in_sample_y,
  input  tmd_pkg::sample_t in_sample_z,
  output logic            win_valid,
  input  logic            win_ready,
  output tmd_pkg::win_t   win
);
  import tmd_pkg::*;

  localparam cnt_t LAST_CNT = CNT_W'(SAMPLES - 1);

  logic    smp_vld_r;
  sample_t smp_r [AXES];
  cnt_t    cnt_r, cnt_nxt;
  sum_t    sum_r [AXES];
  sum_t    sum_nxt [AXES];
  sample_t lo_r [AXES];
  sample_t lo_nxt [AXES];
  sample_t hi_r [AXES];
  sample_t hi_nxt [AXES];
  logic    win_vld_r;
  win_t    win_r, win_nxt;
  logic    win_free, fire, first, last;

  // only the closing sample needs room in the window register
  assign win_free  = !win_vld_r || win_ready;
  assign fire      = smp_vld_r && (!last || win_free);
  assign in_ready  = !smp_vld_r || fire;
  assign first     = (cnt_r == '0);
  assign last      = (cnt_r == LAST_CNT);
  assign win_valid = win_vld_r;
  assign win       = win_r;

  always_comb begin
    cnt_nxt = last ? '0 : cnt_r + 1'b1;
    win_nxt = '0;
    for (int k = 0; k < AXES; k++) begin
      // first sample of a window loads, later ones fold in
      sum_nxt[k] = first ? SUM_W'(smp_r[k]) : sum_r[k] + SUM_W'(smp_r[k]);
      lo_nxt[k]  = (first || (smp_r[k] < lo_r[k])) ? smp_r[k] : lo_r[k];
      hi_nxt[k]  = (first || (smp_r[k] > hi_r[k])) ? smp_r[k] : hi_r[k];
      win_nxt.sum[k] = sum_nxt[k];
      win_nxt.lo[k]  = lo_nxt[k];
      win_nxt.hi[k]  = hi_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
      cnt_r     <= '0;
      win_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        smp_vld_r <= in_valid;
      end
      if (fire) begin
        cnt_r <= cnt_nxt;
      end
      if (win_free) begin
        win_vld_r <= fire && last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r[0] <= in_sample_x;
      smp_r[1] <= in_sample_y;
      smp_r[2] <= in_sample_z;
    end
    if (fire) begin
      for (int k = 0; k < AXES; k++) begin
        sum_r[k] <= sum_nxt[k];
        lo_r[k]  <= lo_nxt[k];
        hi_r[k]  <= hi_nxt[k];
      end
    end
    if (fire && last) begin
      win_r <= win_nxt;
    end
  end

endmodule

@@ rtl/tmd_trim.sv @@
`timescale 1ns / 1ps
module tmd_trim (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           win_valid,
  output logic           win_ready,
  input  tmd_pkg::win_t  win,
  output logic           trim_valid,
  input  logic           trim_ready,
  output tmd_pkg::trim_t trim
);
  import tmd_pkg::*;

  logic  trim_vld_r;
  trim_t trim_r, trim_nxt;
  logic signed [TRIM_W-1:0] tot [AXES];
  logic [TRIM_W-1:0]        mag [AXES];

  assign win_ready  = !trim_vld_r || trim_ready;
  assign trim_valid = trim_vld_r;
  assign trim       = trim_r;

  always_comb begin
    trim_nxt = '0;
    for (int k = 0; k < AXES; k++) begin
      // drop one copy of each extreme
      tot[k] = TRIM_W'($signed(win.sum[k])) - TRIM_W'($signed(win.lo[k]))
             - TRIM_W'($signed(win.hi[k]));
      mag[k] = tot[k][TRIM_W-1] ? (~tot[k] + 1'b1) : tot[k];
      trim_nxt.neg[k] = tot[k][TRIM_W-1];
      trim_nxt.mag[k] = mag[k][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_vld_r <= 1'b0;
    end else if (win_ready) begin
      trim_vld_r <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (win_valid && win_ready) begin
      trim_r <= trim_nxt;
    end
  end

endmodule

@@ rtl/tmd_div.sv @@
`timescale 1ns / 1ps
module tmd_div #(
  parameter int unsigned SAMPLES = tmd_pkg::SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             trim_valid,
  output logic             trim_ready,
  input  tmd_pkg::trim_t   trim,
  output logic             out_valid,
  input  logic             out_ready,
  output tmd_pkg::sample_t out_mean_x,
  output tmd_pkg::sample_t out_mean_y,
  output tmd_pkg::sample_t out_mean_z
);
  import tmd_pkg::*;

  localparam int unsigned    DIVISOR = SAMPLES - 2;
  localparam int unsigned    PROD_W  = MAG_W + RECIP_W;
  // ceil(2^RECIP_SH / DIVISOR): exact for every magnitude below 2^MAG_W
  localparam longint unsigned RECIP_L =
    ((64'd1 << RECIP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_L[RECIP_W-1:0];

  logic              out_vld_r;
  sample_t           mean_r [AXES];
  sample_t           mean_nxt [AXES];
  logic [PROD_W-1:0] prod [AXES];
  logic [QUO_W-1:0]  quo [AXES];
  logic [QUO_W-1:0]  sq [AXES];

  assign trim_ready = !out_vld_r || out_ready;
  assign out_valid  = out_vld_r;
  assign out_mean_x = mean_r[0];
  assign out_mean_y = mean_r[1];
  assign out_mean_z = mean_r[2];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      prod[k] = PROD_W'(trim.mag[k]) * PROD_W'(RECIP);
      quo[k]  = prod[k][RECIP_SH +: QUO_W];
      // restore sign: truncation toward zero
      sq[k]   = trim.neg[k] ? (~quo[k] + 1'b1) : quo[k];
      mean_nxt[k] = sq[k][SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (trim_ready) begin
      out_vld_r <= trim_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (trim_valid && trim_ready) begin
      for (int k = 0; k < AXES; k++) begin
        mean_r[k] <= mean_nxt[k];
      end
    end
  end

endmodule

@@ rtl/three_axis_trimmed_mean_decimator_unit.sv @@
`timescale 1ns / 1ps
// Three-axis trimmed-mean decimator. Each request carries one signed 16-bit
// X/Y/Z sample; every SAMPLES requests make a window, and on the last one of
// each window the block returns one request holding, per axis, the mean of
// the window with one copy of its smallest and one of its largest sample
// dropped, truncated toward zero. The other requests of a window return
// nothing. One request is taken every clock cycle while out_ready is high;
// the closing sample's result passes through the sample register, window
// register, trim register and output register in turn. in_ready follows
// out_ready through the valid bit of each stage, so a stalled output
// holds the whole pipe only once every stage is full. No start-up sweep
// is needed: the window counter clears on reset and the first sample of
// every window reloads the running sums and extremes.
module three_axis_trimmed_mean_decimator_unit #(
  parameter int unsigned SAMPLES = tmd_pkg::SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tmd_pkg::sample_t in_sample_x,
  input  tmd_pkg::sample_t in_sample_y,
  input  tmd_pkg::sample_t in_sample_z,
  output logic             out_valid,
  input  logic             out_ready,
  output tmd_pkg::sample_t out_mean_x,
  output tmd_pkg::sample_t out_mean_y,
  output tmd_pkg::sample_t out_mean_z
);
  import tmd_pkg::*;

  // window totals handed from the accumulator to the trim stage
  logic  win_valid, win_ready;
  win_t  win;
  // sign and magnitude handed from the trim stage to the divider
  logic  trim_valid, trim_ready;
  trim_t trim;

  // Accumulate: hold the sample, fold it into running sum, min and max,
  // and latch the closing totals on the last sample of a window.
  tmd_accum #(
    .SAMPLES (SAMPLES)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample_x (in_sample_x),
    .in_sample_y (in_sample_y),
    .in_sample_z (in_sample_z),
    .win_valid   (win_valid),
    .win_ready   (win_ready),
    .win         (win)
  );

  // Trim: subtract both extremes and split into sign and magnitude.
  tmd_trim u_trim (
    .clk        (clk),
    .rst_n      (rst_n),
    .win_valid  (win_valid),
    .win_ready  (win_ready),
    .win        (win),
    .trim_valid (trim_valid),
    .trim_ready (trim_ready),
    .trim       (trim)
  );

  // Divide by SAMPLES-2 through a reciprocal multiply, then restore sign.
  tmd_div #(
    .SAMPLES (SAMPLES)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .trim_valid (trim_valid),
    .trim_ready (trim_ready),
    .trim       (trim),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_mean_x (out_mean_x),
    .out_mean_y (out_mean_y),
    .out_mean_z (out_mean_z)
  );

endmodule

@@ rtl/tmd_checker.sv @@
`timescale 1ns / 1ps
`include "three_axis_trimmed_mean_decimator_unit_macros.svh"
module tmd_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input tmd_pkg::sample_t out_mean_x,
  input tmd_pkg::sample_t out_mean_y,
  input tmd_pkg::sample_t out_mean_z
);

  // a stalled result keeps its request and its payload
  `TMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mean_x) && $stable(out_mean_y) && $stable(out_mean_z), "result changed while stalled")

  // a free output frees every stage back to the input
  `TMD_ASSERT_IMPL(a_ready_chain, out_ready, in_ready, "input stalled with output free")

  // reset empties the output register
  `TMD_ASSERT_RST(a_rst_empty, !out_valid, "result pending after reset")

  // an input not taken on a free pipe means nothing was offered
  `TMD_ASSERT_IMPL(a_no_stall, in_valid && !in_ready, out_valid && !out_ready, "input stalled without back-pressure")

endmodule

bind three_axis_trimmed_mean_decimator_unit tmd_checker u_tmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_mean_x (out_mean_x),
  .out_mean_y (out_mean_y),
  .out_mean_z (out_mean_z)
);
